### rtl/avm_pkg.sv
// Shared types, field widths and codes for the averaged voltmeter display.
`timescale 1ns / 1ps

package avm_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int READING_W = 6;
  localparam int ENABLE_W  = 2;
  localparam int SEG_W     = 7;

  // item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // digit enable codes
  localparam logic [ENABLE_W-1:0] EN_NONE = 2'd0;
  localparam logic [ENABLE_W-1:0] EN_LOW  = 2'd1;
  localparam logic [ENABLE_W-1:0] EN_HIGH = 2'd2;

  // one input word
  typedef struct packed {
    logic                func;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  // word handed from the input register to the state logic
  typedef struct packed {
    logic  take;
    item_t item;
  } step_t;

endpackage

### rtl/avm_accum.sv
// Sample accumulator and mean-to-tenths-of-a-volt conversion.
`timescale 1ns / 1ps

module avm_accum #(
  parameter int SAMPLES_PER_READING = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  avm_pkg::step_t                step,
  output logic [avm_pkg::READING_W-1:0] reading
);
  import avm_pkg::*;

  localparam int N     = SAMPLES_PER_READING;
  localparam int LOG_N = $clog2(N);
  localparam int SUM_W = SAMPLE_W + LOG_N;
  localparam int CNT_W = (N > 1) ? LOG_N : 1;
  // reciprocal is exact for every sum below 2**SUM_W
  localparam int SHIFT = SUM_W + LOG_N;
  localparam int PROD_W = SUM_W + SHIFT + 1;
  localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'(((1 << SHIFT) + N - 1) / N);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

  logic [SUM_W-1:0]     sample_sum;
  logic [CNT_W-1:0]     sample_count;
  logic [READING_W-1:0] stored_reading;

  logic [SUM_W-1:0]     sum_add;
  logic [PROD_W-1:0]    prod;
  logic [SAMPLE_W-1:0]  mean;
  logic [15:0]          scaled;
  logic [5:0]           q0;
  logic [10:0]          rem;
  logic [READING_W-1:0] reading_next;
  logic                 group_done;
  logic                 take_sample;

  assign take_sample = step.take && (step.item.func == FUNC_SAMPLE);
  assign sum_add     = sample_sum + SUM_W'(step.item.sample);
  assign group_done  = (sample_count == LAST);

  // mean = sum / N by reciprocal
  assign prod = PROD_W'(sum_add) * PROD_W'(RECIP);
  assign mean = prod[SHIFT +: SAMPLE_W];

  // (mean*33 + 511) / 1023: estimate by >>10, then one correction
  assign scaled = {1'b0, mean, 5'b0} + {6'b0, mean} + 16'd511;
  assign q0     = scaled[15:10];
  assign rem    = {1'b0, scaled[9:0]} + {5'b0, q0};
  assign reading_next = (rem >= 11'd1023) ? (q0 + 6'd1) : q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum     <= '0;
      sample_count   <= '0;
      stored_reading <= '0;
    end else if (take_sample) begin
      if (group_done) begin
        sample_sum     <= '0;
        sample_count   <= '0;
        stored_reading <= reading_next;
      end else begin
        sample_sum   <= sum_add;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  assign reading = stored_reading;

endmodule

### rtl/avm_display.sv
// Digit split, seven-segment coding and digit multiplexing.
`timescale 1ns / 1ps

module avm_display (
  input  logic                          clk,
  input  logic                          rst,
  input  avm_pkg::step_t                step,
  input  logic [avm_pkg::READING_W-1:0] reading,
  output logic [avm_pkg::ENABLE_W-1:0]  digit_enable,
  output logic [avm_pkg::SEG_W-1:0]     segments
);
  import avm_pkg::*;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] c;
    case (d)
      4'd0:    c = 7'h3F;
      4'd1:    c = 7'h06;
      4'd2:    c = 7'h5B;
      4'd3:    c = 7'h4F;
      4'd4:    c = 7'h66;
      4'd5:    c = 7'h6D;
      4'd6:    c = 7'h7D;
      4'd7:    c = 7'h07;
      4'd8:    c = 7'h7F;
      4'd9:    c = 7'h6F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  logic                 high_digit_next;
  logic [ENABLE_W-1:0]  drive_enable;
  logic [SEG_W-1:0]     drive_segments;

  logic [3:0]           hi;
  logic [READING_W-1:0] lo_full;
  logic [3:0]           lo;
  logic                 take_tick;

  assign take_tick = step.take && (step.item.func == FUNC_TICK);

  // tens digit by compare chain; reading is below 64
  always_comb begin
    if      (reading >= 6'd60) hi = 4'd6;
    else if (reading >= 6'd50) hi = 4'd5;
    else if (reading >= 6'd40) hi = 4'd4;
    else if (reading >= 6'd30) hi = 4'd3;
    else if (reading >= 6'd20) hi = 4'd2;
    else if (reading >= 6'd10) hi = 4'd1;
    else                       hi = 4'd0;
  end

  assign lo_full = reading - READING_W'({hi, 3'b0} + {2'b0, hi, 1'b0});
  assign lo      = lo_full[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      high_digit_next <= 1'b0;
      drive_enable    <= EN_NONE;
      drive_segments  <= '0;
    end else if (take_tick) begin
      high_digit_next <= !high_digit_next;
      if (high_digit_next) begin
        drive_enable   <= EN_HIGH;
        drive_segments <= seg_code(hi);
      end else begin
        drive_enable   <= EN_LOW;
        drive_segments <= seg_code(lo);
      end
    end
  end

  assign digit_enable = drive_enable;
  assign segments     = drive_segments;

endmodule

### rtl/averaged_voltmeter_display_mux.sv
// Top level of the averaged voltmeter with multiplexed two-digit display.
//
//   channel | direction | handshake                  | word
//   item    | in        | item_valid / item_stall    | func, sample
//   result  | out       | result_valid / result_stall| digit_enable, segments, reading
//
// Every accepted item gives one result word: it is held in the input
// register, then passes through the accumulator or display logic into
// the state registers, which double as the result register.
// One item per cycle is sustained while results are not stalled; the longest
// path is the reciprocal multiply and the /1023 correction in the accumulator.
// rst is synchronous: it empties both stages and clears the sum, count,
// reading and display drive. A stalled result holds the state and stalls
// the input only once the input register is also full.
`timescale 1ns / 1ps

module averaged_voltmeter_display_mux #(
  parameter int SAMPLES_PER_READING = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          func,
  input  logic [avm_pkg::SAMPLE_W-1:0]  sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [avm_pkg::ENABLE_W-1:0]  digit_enable,
  output logic [avm_pkg::SEG_W-1:0]     segments,
  output logic [avm_pkg::READING_W-1:0] reading
);
  import avm_pkg::*;

  // input register
  logic  in_full;
  item_t in_item;

  logic  advance;
  step_t step;

  // move the held word into the state when the result slot is free
  assign advance    = in_full && !(result_valid && result_stall);
  assign item_stall = in_full && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!item_stall) begin
      in_item.func   <= func;
      in_item.sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign step.take = advance;
  assign step.item = in_item;

  avm_accum #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .reading(reading)
  );

  avm_display u_display (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .reading     (reading),
    .digit_enable(digit_enable),
    .segments    (segments)
  );

endmodule

### rtl/avm_checker.sv
// Port-level checks on the voltmeter top level, bound to it below.
`timescale 1ns / 1ps

module avm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [avm_pkg::ENABLE_W-1:0]  digit_enable,
  input logic [avm_pkg::SEG_W-1:0]     segments,
  input logic [avm_pkg::READING_W-1:0] reading
);
  import avm_pkg::*;

  // a stalled result word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(digit_enable) && $stable(segments) && $stable(reading))
    else $error("stalled result word changed");

  // segments lit exactly when a digit is driven
  a_dark: assert property (@(posedge clk) disable iff (rst)
    (digit_enable == EN_NONE) == (segments == '0))
    else $error("segments and digit enable disagree");

  // reading stays in range while a word is shown
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> reading <= 6'd33)
    else $error("reading out of range");

  // drive alternates low, high, low, ...
  a_alt: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (digit_enable != $past(digit_enable)) |->
      (digit_enable == EN_HIGH && $past(digit_enable) == EN_LOW) ||
      (digit_enable == EN_LOW && ($past(digit_enable) == EN_HIGH ||
                                  $past(digit_enable) == EN_NONE)))
    else $error("digit drive out of order");

endmodule

bind averaged_voltmeter_display_mux avm_checker u_avm_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .digit_enable(digit_enable),
  .segments    (segments),
  .reading     (reading)
);

### sim/tb_averaged_voltmeter_display_mux.sv
// Self-checking testbench for the averaged voltmeter with multiplexed display.
`timescale 1ns / 1ps

module tb_averaged_voltmeter_display_mux;
  import avm_pkg::*;

  // Run shape
  localparam int GROUP_LEN    = 8;       // samples per averaged reading
  localparam int RAND_WORDS   = 950;     // random input words after the table
  localparam int CALM_WORDS   = 80;      // tail of the run with no idling
  localparam int CYCLE_LIMIT  = 400000;  // watchdog, far above the slowest legal run
  localparam int DRAIN_CYCLES = 8;       // settle time after the last expected result word
  localparam int MAX_REPORTS  = 10;

  // One result word, packed so a whole-word compare is one operation
  typedef struct packed {
    logic [ENABLE_W-1:0]  en;
    logic [SEG_W-1:0]     seg;
    logic [READING_W-1:0] rd;
  } drive_t;

  // One row of the directed table; 'typed' rows carry a hand-written result
  typedef struct {
    logic                f;
    logic [SAMPLE_W-1:0] s;
    bit                  typed;
    drive_t              want;
  } stim_row_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  logic                 func         = FUNC_SAMPLE;
  logic [SAMPLE_W-1:0]  sample       = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [ENABLE_W-1:0]  digit_enable;
  logic [SEG_W-1:0]     segments;
  logic [READING_W-1:0] reading;

  averaged_voltmeter_display_mux #(
    .SAMPLES_PER_READING(GROUP_LEN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .func        (func),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .digit_enable(digit_enable),
    .segments    (segments),
    .reading     (reading)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: own copy of the accumulator and display drive
  // ---------------------------------------------------------------------
  logic [12:0]          acc_sum   = '0;   // 8 x 1023 fits in 13 bits
  logic [2:0]           acc_cnt   = '0;
  logic [READING_W-1:0] volts     = '0;   // tenths of a volt, 0..33
  logic                 show_high = 1'b0; // next tick drives the high digit
  drive_t               drive     = '0;   // nothing lit until the first tick

  drive_t    expected_drive_q[$];
  stim_row_t directed_rows[$];

  int unsigned words_sent  = 0;
  int unsigned ticks_sent  = 0;
  int unsigned groups_done = 0;
  int unsigned words_checked = 0;
  int unsigned errors      = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned gap_pct     = 0;
  bit          calm        = 1'b0;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    case (d)
      4'd0: return 7'h3F;
      4'd1: return 7'h06;
      4'd2: return 7'h5B;
      4'd3: return 7'h4F;
      4'd4: return 7'h66;
      4'd5: return 7'h6D;
      4'd6: return 7'h7D;
      4'd7: return 7'h07;
      4'd8: return 7'h7F;
      4'd9: return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

  // Advance the predicted state by one accepted word and return its result
  function automatic drive_t meter_step(input logic f, input logic [SAMPLE_W-1:0] s);
    int unsigned mean;
    acc_sum = acc_sum + s;
    if (f == FUNC_SAMPLE) begin
      if (acc_cnt == 3'(GROUP_LEN - 1)) begin
        // last slot of the group: reading updates and is visible in this word
        mean    = acc_sum / GROUP_LEN;
        volts   = READING_W'((mean * 33 + 511) / 1023);
        acc_sum = '0;
        acc_cnt = '0;
        groups_done++;
      end else begin
        acc_cnt = acc_cnt + 3'd1;
      end
    end else begin
      // tick: undo the add above, group in progress is untouched
      acc_sum = acc_sum - s;
      if (!show_high) begin
        drive.en  = EN_LOW;
        drive.seg = seg_of(4'(volts % 10));
      end else begin
        drive.en  = EN_HIGH;
        drive.seg = seg_of(4'(volts / 10));
      end
      show_high = !show_high;
    end
    drive.rd = volts;
    return drive;
  endfunction

  function automatic void add_row(input logic f, input logic [SAMPLE_W-1:0] s,
                                  input bit typed, input logic [ENABLE_W-1:0] en,
                                  input logic [SEG_W-1:0] seg,
                                  input logic [READING_W-1:0] rd);
    stim_row_t r;
    r.f     = f;
    r.s     = s;
    r.typed = typed;
    r.want  = '{en: en, seg: seg, rd: rd};
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Input side: hold the word until it is taken, then log its result.
  // item_stall is read right after the edge, i.e. its pre-edge value.
  // ---------------------------------------------------------------------
  task automatic send_word(input logic f, input logic [SAMPLE_W-1:0] s,
                           input bit typed, input drive_t want);
    drive_t pred;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid <= 1'b1;
    func       <= f;
    sample     <= s;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = meter_step(f, s);
    expected_drive_q.push_back(typed ? want : pred);
    words_sent++;
    if (f == FUNC_TICK) ticks_sent++;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall bursts, none in the calm tail
  // ---------------------------------------------------------------------
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
        // occasionally a long stretch with no back-pressure
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 30)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: every taken result word against the oldest expectation
  // ---------------------------------------------------------------------
  drive_t got_drive, want_drive;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got_drive = '{en: digit_enable, seg: segments, rd: reading};
      if (expected_drive_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("[%0t] result word with nothing pending: en=%0d seg=%02h rd=%0d",
                   $realtime, got_drive.en, got_drive.seg, got_drive.rd);
        errors++;
      end else begin
        want_drive = expected_drive_q.pop_front();
        words_checked++;
        if (got_drive !== want_drive) begin
          if (errors < MAX_REPORTS)
            $display("[%0t] mismatch: en exp %0d got %0d, seg exp %02h got %02h, rd exp %0d got %0d",
                     $realtime, want_drive.en, got_drive.en, want_drive.seg, got_drive.seg,
                     want_drive.rd, got_drive.rd);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d result words still pending",
             cycle_cnt, expected_drive_q.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int          i;
    int          lvl;
    int          val;
    logic        f;
    logic [SAMPLE_W-1:0] s;
    drive_t      unused;

    unused = '0;

    // Directed table.
    // Before any tick nothing is lit; the reading is still shown.
    add_row(FUNC_SAMPLE, 10'h3FF, 1, EN_NONE, 7'h00, 6'd0);
    // Tick carries a full-scale sample that must be ignored; group stays at 1.
    add_row(FUNC_TICK,   10'h3FF, 1, EN_LOW,  7'h3F, 6'd0);
    for (i = 0; i < 6; i++)
      add_row(FUNC_SAMPLE, 10'h3FF, 0, EN_NONE, 7'h00, 6'd0);
    // Eighth full-scale sample closes the group: top of range, 3.3 V.
    add_row(FUNC_SAMPLE, 10'h3FF, 1, EN_LOW,  7'h3F, 6'd33);
    add_row(FUNC_TICK,   10'h000, 1, EN_HIGH, 7'h4F, 6'd33);
    add_row(FUNC_TICK,   10'h155, 1, EN_LOW,  7'h4F, 6'd33);
    // Alternating bit patterns, averaging to mid scale.
    for (i = 0; i < GROUP_LEN; i++)
      add_row(FUNC_SAMPLE, (i % 2) ? 10'h155 : 10'h2AA, 0, EN_NONE, 7'h00, 6'd0);
    add_row(FUNC_TICK,   10'h2AA, 0, EN_NONE, 7'h00, 6'd0);
    add_row(FUNC_TICK,   10'h000, 0, EN_NONE, 7'h00, 6'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 15;
    foreach (directed_rows[k])
      send_word(directed_rows[k].f, directed_rows[k].s, directed_rows[k].typed,
                directed_rows[k].want);

    // Random part: each group aims at one level with small jitter so the
    // readings spread over the whole 0..33 range; some words are plain noise.
    lvl = 0;
    for (i = 0; i < RAND_WORDS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      if (i >= RAND_WORDS - CALM_WORDS) calm = 1'b1;

      if ($urandom_range(0, 99) < 35) begin
        f = FUNC_TICK;
        s = SAMPLE_W'($urandom);
      end else begin
        f = FUNC_SAMPLE;
        if (acc_cnt == 3'd0) begin
          case ($urandom_range(0, 7))
            0: lvl = 0;
            1: lvl = 1023;
            default: lvl = $urandom_range(0, 1023);
          endcase
        end
        if ($urandom_range(0, 99) < 15) begin
          val = $urandom_range(0, 1023);
        end else begin
          val = lvl + $urandom_range(0, 16) - 8;
          if (val < 0) val = 0;
          if (val > 1023) val = 1023;
        end
        s = SAMPLE_W'(val);
      end
      send_word(f, s, 0, unused);
    end
    item_valid <= 1'b0;

    // Drain, then let the pipeline settle in case of stray words
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input words (%0d refresh ticks, %0d sample groups closed).",
             words_sent, ticks_sent, groups_done);
    $display("Checked %0d result words, %0d mismatches or stray words.",
             words_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/avm_pkg.sv
rtl/avm_accum.sv
rtl/avm_display.sv
rtl/averaged_voltmeter_display_mux.sv
rtl/avm_checker.sv
sim/tb_averaged_voltmeter_display_mux.sv
